// ===== hw/rtl/cht_pkg.sv =====
package cht_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Defaults for the top-level parameters.
    localparam int LOG2_SLOTS_DEF = 10;
    localparam int TAG_BITS_DEF   = 32;

    // Configuration port layout.
    localparam int         ADDR_W       = 3;
    localparam logic       REG_CAPACITY = 1'b0;
    localparam logic [3:0] CAP_RESET    = 4'd10;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;   // latch the accepted item and launch the memory reads
        logic exec;   // decide, update the table and load the result register
    } t_cmd;

endpackage

// ===== hw/rtl/cht_if.sv =====
interface cht_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [63:0] handle_id;
    logic [63:0] random_bits;
    logic [31:0] owner_tag;

    modport source (output valid, output operation, output handle_id,
                    output random_bits, output owner_tag, input ready);
    modport sink (input valid, input operation, input handle_id,
                  input random_bits, input owner_tag, output ready);
endinterface

interface cht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [63:0] assigned_id;
    logic [31:0] found_tag;

    modport source (output valid, output status, output assigned_id,
                    output found_tag, input ready);
    modport sink (input valid, input status, input assigned_id,
                  input found_tag, output ready);
endinterface

// ===== hw/rtl/cht_ctrl.sv =====
module cht_ctrl
    import cht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;
    logic r_out_valid;
    logic n_out_valid;
    logic slot_free;

    // The result register can take a new result when it is empty or drains now.
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                if (slot_free) begin
                    o_cmd.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/cht_dp.sv =====
module cht_dp
    import cht_pkg::*;
#(
    parameter int LOG2_SLOTS = LOG2_SLOTS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [3:0]  i_cap,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_handle_id,
    input  logic [63:0] i_random_bits,
    input  logic [31:0] i_owner_tag,
    output logic [1:0]  o_status,
    output logic [63:0] o_assigned_id,
    output logic [31:0] o_found_tag
);

    localparam int L     = LOG2_SLOTS;
    localparam int SLOTS = 1 << LOG2_SLOTS;
    localparam int CW    = LOG2_SLOTS + 1;
    localparam int EW    = $clog2(LOG2_SLOTS + 1);
    localparam int TW    = (TAG_BITS < 32) ? TAG_BITS : 32;

    // Slot store: valid bit, id and tag per slot, plus the free-list links.
    logic          m_valid [SLOTS];
    logic [63:0]   m_id    [SLOTS];
    logic [TW-1:0] m_tag   [SLOTS];
    logic [L-1:0]  m_next  [SLOTS];

    // Held item.
    logic [1:0]    r_op;
    logic [63:0]   r_hid;
    logic [63:0]   r_rnd;
    logic [TW-1:0] r_tag;

    // Table bookkeeping.
    logic [CW-1:0] r_region,    n_region;
    logic [CW-1:0] r_count,     n_count;
    logic [CW-1:0] r_xcount,    n_xcount;
    logic [L-1:0]  r_head,      n_head;
    logic          r_fresh_any, n_fresh_any;
    logic [L-1:0]  r_fresh_lo,  n_fresh_lo;
    logic [L-1:0]  r_fresh_top, n_fresh_top;

    // Registered memory read data.
    logic          r_rd_valid;
    logic [63:0]   r_rd_id;
    logic [TW-1:0] r_rd_tag;
    logic [L-1:0]  r_rd_next;

    // Result register.
    logic [1:0]    r_status,  n_status;
    logic [63:0]   r_aid,     n_aid;
    logic [31:0]   r_ftag,    n_ftag;

    logic [EW-1:0] eff;
    logic [63:0]   mask64;
    logic [L-1:0]  mask_l;
    logic [CW-1:0] max_slots;
    logic [L-1:0]  rd_idx;
    logic [L-1:0]  key_idx;

    logic          free_none;
    logic          full;
    logic          grow;
    logic [CW-1:0] grow_region;
    logic [CW-1:0] grow_top;
    logic [L-1:0]  pop_idx;
    logic          in_region;
    logic          in_fresh;
    logic          hit;
    logic [CW-1:0] count_dec;

    logic          wr_valid_en;
    logic          wr_valid_val;
    logic          wr_entry_en;
    logic          wr_next_en;
    logic [L-1:0]  wr_idx;
    logic [63:0]   wr_id;

    // Effective capacity (log2) saturates at the log2 slot count of this build.
    assign eff       = (32'(i_cap) > LOG2_SLOTS) ? EW'(LOG2_SLOTS) : EW'(i_cap);
    assign mask64    = (64'd1 << eff) - 64'd1;
    assign mask_l    = mask64[L-1:0];
    assign max_slots = CW'(1) << eff;

    assign key_idx = r_hid[L-1:0] & mask_l;
    assign rd_idx  = i_cmd.load ? (i_handle_id[L-1:0] & mask_l) : key_idx;

    // Add: pop the explicit list, then the fresh range, else grow the region.
    assign free_none   = (r_count == r_region);
    assign full        = free_none && (r_count >= max_slots);
    assign grow        = free_none && !full;
    assign grow_region = (r_region == '0) ? CW'(1) : (r_region << 1);
    assign grow_top    = grow_region - CW'(1);

    always_comb begin
        if (grow) begin
            pop_idx = grow_top[L-1:0];
        end else if (r_xcount != '0) begin
            pop_idx = r_head;
        end else begin
            pop_idx = r_fresh_top;
        end
    end

    // Delete and lookup: a slot in the not yet handed out range is free.
    assign in_region = ({1'b0, key_idx} < r_region);
    assign in_fresh  = r_fresh_any && (key_idx >= r_fresh_lo) && (key_idx <= r_fresh_top);
    assign hit       = in_region && !in_fresh && r_rd_valid && (r_rd_id == r_hid);
    assign count_dec = r_count - CW'(1);
    assign wr_id     = {{(64 - L){1'b0}}, pop_idx} ^ (r_rnd & ~mask64);

    always_comb begin
        n_region     = r_region;
        n_count      = r_count;
        n_xcount     = r_xcount;
        n_head       = r_head;
        n_fresh_any  = r_fresh_any;
        n_fresh_lo   = r_fresh_lo;
        n_fresh_top  = r_fresh_top;
        n_status     = ST_NOT_FOUND;
        n_aid        = '0;
        n_ftag       = '0;
        wr_valid_en  = 1'b0;
        wr_valid_val = 1'b0;
        wr_entry_en  = 1'b0;
        wr_next_en   = 1'b0;
        wr_idx       = key_idx;
        case (r_op)
            OP_ADD: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status     = ST_OK;
                    n_aid        = wr_id;
                    n_count      = r_count + CW'(1);
                    wr_idx       = pop_idx;
                    wr_valid_en  = 1'b1;
                    wr_valid_val = 1'b1;
                    wr_entry_en  = 1'b1;
                    if (grow) begin
                        n_region    = grow_region;
                        n_fresh_lo  = r_region[L-1:0];
                        n_fresh_any = (grow_top != r_region);
                        n_fresh_top = pop_idx - L'(1);
                    end else if (r_xcount != '0) begin
                        n_head   = r_rd_next;
                        n_xcount = r_xcount - CW'(1);
                    end else begin
                        n_fresh_any = (r_fresh_top != r_fresh_lo);
                        n_fresh_top = r_fresh_top - L'(1);
                    end
                end
            end
            OP_DELETE, OP_LOOKUP: begin
                if (hit) begin
                    n_status = ST_OK;
                    n_ftag   = 32'(r_rd_tag);
                    if (r_op == OP_DELETE) begin
                        wr_valid_en = 1'b1;
                        wr_next_en  = 1'b1;
                        if (count_dec == '0) begin
                            // Last entry gone: back to the empty layout.
                            n_region    = '0;
                            n_count     = '0;
                            n_xcount    = '0;
                            n_head      = '0;
                            n_fresh_any = 1'b0;
                        end else begin
                            n_count  = count_dec;
                            n_xcount = r_xcount + CW'(1);
                            n_head   = key_idx;
                        end
                    end
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= m_valid[rd_idx];
        r_rd_id    <= m_id[rd_idx];
        r_rd_tag   <= m_tag[rd_idx];
        r_rd_next  <= m_next[r_head];
        if (i_cmd.exec && wr_valid_en) begin
            m_valid[wr_idx] <= wr_valid_val;
        end
        if (i_cmd.exec && wr_entry_en) begin
            m_id[wr_idx]  <= wr_id;
            m_tag[wr_idx] <= r_tag;
        end
        if (i_cmd.exec && wr_next_en) begin
            m_next[wr_idx] <= r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_operation;
            r_hid <= i_handle_id;
            r_rnd <= i_random_bits;
            r_tag <= i_owner_tag[TW-1:0];
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_aid    <= n_aid;
            r_ftag   <= n_ftag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region    <= '0;
            r_count     <= '0;
            r_xcount    <= '0;
            r_head      <= '0;
            r_fresh_any <= 1'b0;
            r_fresh_lo  <= '0;
            r_fresh_top <= '0;
        end else if (i_cmd.exec) begin
            r_region    <= n_region;
            r_count     <= n_count;
            r_xcount    <= n_xcount;
            r_head      <= n_head;
            r_fresh_any <= n_fresh_any;
            r_fresh_lo  <= n_fresh_lo;
            r_fresh_top <= n_fresh_top;
        end
    end

    assign o_status      = r_status;
    assign o_assigned_id = r_aid;
    assign o_found_tag   = r_ftag;

endmodule

// ===== hw/rtl/connection_handle_table_unit.sv =====
// Channel  | Direction | Handshake     | Payload
// i_req    | in        | valid / ready | operation, handle_id, random_bits, owner_tag
// o_rsp    | out       | valid / ready | status, assigned_id, found_tag
// APB      | in / out  | psel/penable  | capacity_log2 at byte address 0
//
// Every item passes through the accept state, which launches the registered read of
// the slot store and of the free-list link memory, and then the execute state, which
// decides, updates the table and loads the result register.
// A stalled result register holds the item in the execute state until it drains.
// Reset is synchronous; the slot store needs no clearing pass, because a slot is
// only believed when it lies inside the grown region and outside the range of
// slots that growth made free but that have not yet been handed out.
module connection_handle_table_unit
    import cht_pkg::*;
#(
    parameter int LOG2_SLOTS = LOG2_SLOTS_DEF,
    parameter int TAG_BITS   = TAG_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cht_req_if.sink           i_req,
    cht_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cmd       cmd;
    logic [3:0] r_cap;
    logic       cap_sel;

    // The capacity register is the only register; its index is the word address.
    assign cap_sel = (paddr[2] == REG_CAPACITY);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? {28'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (psel && penable && pwrite && cap_sel) begin
            r_cap <= pwdata[3:0];
        end
    end

    // The controller sequences each item and owns the result valid flag.
    cht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the slot store, the free list and the result register.
    cht_dp #(
        .LOG2_SLOTS (LOG2_SLOTS),
        .TAG_BITS   (TAG_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cap         (r_cap),
        .i_operation   (i_req.operation),
        .i_handle_id   (i_req.handle_id),
        .i_random_bits (i_req.random_bits),
        .i_owner_tag   (i_req.owner_tag),
        .o_status      (o_rsp.status),
        .o_assigned_id (o_rsp.assigned_id),
        .o_found_tag   (o_rsp.found_tag)
    );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the connection handle table. Requests are pushed into
// a send queue by the stimulus process and handed to the block by a clocked
// driver. The driver also keeps a software copy of the table: every accepted
// request is applied to that copy and the reply it must produce is queued. A
// clocked monitor takes each reply the block hands back and compares it,
// field by field, with the oldest queued reply.
module testbench;
    import cht_pkg::*;

    // Table geometry, taken from the defaults the block is built with.
    localparam int IDX_W = LOG2_SLOTS_DEF;
    localparam int CNT_W = IDX_W + 1;
    localparam int SLOTS = 1 << IDX_W;
    localparam logic [31:0] TAG_KEEP = (TAG_BITS_DEF >= 32) ? 32'hFFFF_FFFF
                                     : 32'((64'd1 << TAG_BITS_DEF) - 64'd1);

    // The block has no name for the fourth operation code; it must answer
    // it like a lookup that misses.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // The capacity register sits at byte address four times its index.
    localparam logic [ADDR_W-1:0] CAP_ADDR = ADDR_W'(4 * int'(REG_CAPACITY));

    // Timing of the run.
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] hid;
        logic [63:0] rnd;
        logic [31:0] tag;
    } handle_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] aid;
        logic [31:0] tag;
    } handle_rsp_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Configuration port, driven only by the stimulus process.
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Request and reply channels. The bench drives its side of both through
    // plain variables so that every input is known from time zero.
    cht_req_if req_bus ();
    cht_rsp_if rsp_bus ();

    logic        drv_valid = 1'b0;
    handle_req_t drv_item  = '0;
    logic        mon_ready = 1'b0;

    assign req_bus.valid       = drv_valid;
    assign req_bus.operation   = drv_item.op;
    assign req_bus.handle_id   = drv_item.hid;
    assign req_bus.random_bits = drv_item.rnd;
    assign req_bus.owner_tag   = drv_item.tag;
    assign rsp_bus.ready       = mon_ready;

    connection_handle_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Software copy of the table. It is only written by the driver, at the
    // clock edge where a request or a register write takes effect.
    logic                slot_used  [SLOTS];
    logic [IDX_W-1:0]    slot_link  [SLOTS];
    logic [63:0]         slot_hid   [SLOTS];
    logic [31:0]         slot_owner [SLOTS];
    logic [IDX_W-1:0]    free_top;
    logic                free_none;
    logic [CNT_W-1:0]    grown_slots;
    logic [CNT_W-1:0]    live_count;
    logic [3:0]          capacity_log2;

    // Bookkeeping shared by the processes.
    handle_req_t items_to_send [$];
    handle_rsp_t replies_due   [$];
    int          n_queued     = 0;
    int          n_accepted   = 0;
    int          mismatches   = 0;
    int          send_gap     = 0;
    int          recv_stall   = 0;
    int          quiet_cycles = 0;
    logic        idle_on      = 1'b1;
    logic        hold_rsp     = 1'b0;

    // Puts a slot back on top of the free list.
    function automatic void release_slot(input logic [IDX_W-1:0] idx);
        slot_used[idx] = 1'b0;
        slot_link[idx] = free_top;
        free_top       = idx;
        free_none      = 1'b0;
    endfunction

    // Back to the empty layout. The capacity setting is left alone.
    function automatic void wipe_table();
        for (int s = 0; s < SLOTS; s++) begin
            slot_used[s]  = 1'b0;
            slot_link[s]  = '0;
            slot_hid[s]   = '0;
            slot_owner[s] = '0;
        end
        free_top    = '0;
        free_none   = 1'b1;
        grown_slots = '0;
        live_count  = '0;
    endfunction

    // Applies one accepted request to the software table and returns the
    // reply that the block owes for it.
    function automatic handle_rsp_t apply_to_table(input handle_req_t it);
        handle_rsp_t      res;
        logic [63:0]      keep;
        logic [IDX_W-1:0] idx;
        int               eff;
        int               grow_end;
        logic             admit;
        // Capacities beyond the table size saturate at the table size.
        eff  = (int'(capacity_log2) > IDX_W) ? IDX_W : int'(capacity_log2);
        keep = (64'd1 << eff) - 64'd1;
        res  = '{status: ST_NOT_FOUND, aid: 64'd0, tag: 32'd0};
        case (it.op)
            OP_ADD: begin
                admit = 1'b1;
                if (free_none) begin
                    // Out of free slots: refuse at the capacity limit, else
                    // grow the in-use region (0 to 1, then doubling) and push
                    // the new slots in ascending order.
                    if (64'(live_count) > keep) begin
                        admit = 1'b0;
                    end else if (grown_slots == 0) begin
                        grown_slots = CNT_W'(1);
                        release_slot('0);
                    end else begin
                        grow_end = 2 * int'(grown_slots);
                        if (grow_end > SLOTS)
                            grow_end = SLOTS;
                        for (int s = int'(grown_slots); s < grow_end; s++)
                            release_slot(IDX_W'(s));
                        grown_slots = CNT_W'(grow_end);
                    end
                end
                if (admit && !free_none) begin
                    idx             = free_top;
                    free_top        = slot_link[idx];
                    live_count      = live_count + 1'b1;
                    free_none       = (live_count >= grown_slots);
                    res.aid         = 64'(idx) ^ (it.rnd & ~keep);
                    slot_used[idx]  = 1'b1;
                    slot_hid[idx]   = res.aid;
                    slot_owner[idx] = it.tag & TAG_KEEP;
                    res.status      = ST_OK;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_DELETE, OP_LOOKUP: begin
                // The index comes from the low id bits under the current mask;
                // the slot must be in the region, valid and hold the full id.
                if ((it.hid & keep) < 64'(grown_slots)) begin
                    idx = IDX_W'(it.hid & keep);
                    if (slot_used[idx] && slot_hid[idx] == it.hid) begin
                        res.status = ST_OK;
                        res.tag    = slot_owner[idx];
                        if (it.op == OP_DELETE) begin
                            release_slot(idx);
                            if (live_count != 0)
                                live_count = live_count - 1'b1;
                            // Removing the last entry resets the whole table.
                            if (live_count == 0)
                                wipe_table();
                        end
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic handle_req_t make_item(input logic [1:0] op, input logic [63:0] hid,
                                              input logic [63:0] rnd, input logic [31:0] tag);
        handle_req_t it;
        it = '{op: op, hid: hid, rnd: rnd, tag: tag};
        return it;
    endfunction

    // A random request. Deletes and lookups mostly carry an id that is live in
    // the software table (possibly slightly stale, which is fine), sometimes
    // with one bit flipped, and sometimes a fully random id.
    function automatic handle_req_t random_item(input int add_pct);
        handle_req_t it;
        int          roll;
        int          slot;
        logic        hit;
        it   = make_item(OP_ADD, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
        hit  = 1'b0;
        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
            it.op = OP_UNUSED;
        end else if (roll >= add_pct) begin
            it.op = $urandom_range(0, 1) ? OP_DELETE : OP_LOOKUP;
            roll  = $urandom_range(0, 9);
            if (roll < 8 && grown_slots != 0) begin
                for (int t = 0; t < 4 && !hit; t++) begin
                    slot = $urandom_range(0, int'(grown_slots) - 1);
                    if (slot_used[slot]) begin
                        it.hid = slot_hid[slot];
                        hit    = 1'b1;
                    end
                end
                if (roll == 7)
                    it.hid[$urandom_range(0, 63)] ^= 1'b1;
            end
        end
        return it;
    endfunction

    function automatic void queue_item(input handle_req_t it);
        items_to_send.push_back(it);
        n_queued++;
    endfunction

    // Each mismatch is counted; the printout is capped so that a badly broken
    // block does not flood the log.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch in %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Waits until every queued request has been taken and answered, then
    // lets the pipeline settle.
    task automatic wait_idle();
        while (n_accepted != n_queued || replies_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access phase meets pready.
    task automatic write_capacity(input logic [3:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CAP_ADDR;
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random(input int count, input int add_pct);
        // Requests are generated only a few ahead of the block, so that the
        // ids they carry are mostly still live when they arrive.
        for (int k = 0; k < count; k++) begin
            while (items_to_send.size() >= 4)
                @(posedge i_clk);
            queue_item(random_item(add_pct));
        end
    endtask

    // Driver: offers queued requests, with random gaps between them, and
    // runs every accepted request through the software table. Register writes
    // are picked up from the port at the edge where the block takes them.
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            wipe_table();
            capacity_log2 = CAP_RESET;
            drv_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
                capacity_log2 = pwdata[3:0];
            if (drv_valid && req_bus.ready) begin
                replies_due.push_back(apply_to_table(drv_item));
                n_accepted++;
            end
            if (!drv_valid || req_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    drv_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    drv_item  <= items_to_send.pop_front();
                    drv_valid <= 1'b1;
                    send_gap = idle_on ? pick_gap() : 0;
                end else begin
                    drv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes replies, with random stalls and the long hold-off that
    // the stimulus asks for, and checks each one against the oldest owed reply.
    always @(posedge i_clk) begin : monitor
        handle_rsp_t want;
        if (!i_rst_n) begin
            mon_ready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (rsp_bus.valid && mon_ready) begin
                if (replies_due.size() == 0) begin
                    report_mismatch("unexpected reply", rsp_bus.assigned_id, 64'd0);
                end else begin
                    want = replies_due.pop_front();
                    if (rsp_bus.status !== want.status)
                        report_mismatch("status", 64'(rsp_bus.status), 64'(want.status));
                    if (rsp_bus.assigned_id !== want.aid)
                        report_mismatch("assigned_id", rsp_bus.assigned_id, want.aid);
                    if (rsp_bus.found_tag !== want.tag)
                        report_mismatch("found_tag", 64'(rsp_bus.found_tag), 64'(want.tag));
                end
            end
            if (recv_stall > 0)
                recv_stall--;
            else if (idle_on && $urandom_range(0, 3) == 0)
                recv_stall = pick_gap();
            mon_ready <= !hold_rsp && recv_stall == 0;
        end
    end

    // Watchdog: a long run of cycles with no handshake on any port means the
    // block has hung.
    always @(posedge i_clk) begin : watchdog
        if ((drv_valid && req_bus.ready) || (rsp_bus.valid && mon_ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin : stimulus
        int start;
        int s;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity. Every miss on an empty table
        // and the unused operation code must answer not found.
        queue_item(make_item(OP_LOOKUP, 64'd0, 64'd0, 32'd0));
        queue_item(make_item(OP_DELETE, '1, '1, '1));
        queue_item(make_item(OP_UNUSED, 64'd0, '1, '1));
        // Growth 0 -> 1 -> 2 -> 4: slots come out as 0, 1, 3, 2.
        queue_item(make_item(OP_ADD, 64'd0, '1, '1));
        queue_item(make_item(OP_ADD, '1, 64'd0, 32'h0000_0001));
        queue_item(make_item(OP_ADD, 64'd0, 64'h5555_5555_5555_5555, 32'h5555_5555));
        queue_item(make_item(OP_ADD, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA));
        // Hit, wrong upper bits, index past the region.
        queue_item(make_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FC00, 64'd0, 32'd0));
        queue_item(make_item(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FC00, 64'd0, 32'd0));
        queue_item(make_item(OP_LOOKUP, 64'd5, 64'd0, 32'd0));
        // Delete, then a lookup of the freed slot; the next add reuses it.
        queue_item(make_item(OP_DELETE, 64'd1, 64'd0, 32'd0));
        queue_item(make_item(OP_LOOKUP, 64'd1, 64'd0, 32'd0));
        queue_item(make_item(OP_ADD, 64'd0, 64'h0000_0000_0000_0400, 32'd0));
        // Empty the table; the last delete clears it back to the reset layout.
        queue_item(make_item(OP_DELETE, 64'hFFFF_FFFF_FFFF_FC00, 64'd0, 32'd0));
        queue_item(make_item(OP_DELETE, 64'h5555_5555_5555_5403, 64'd0, 32'd0));
        queue_item(make_item(OP_DELETE, 64'hAAAA_AAAA_AAAA_A802, 64'd0, 32'd0));
        queue_item(make_item(OP_DELETE, 64'h0000_0000_0000_0401, 64'd0, 32'd0));
        queue_item(make_item(OP_LOOKUP, 64'h0000_0000_0000_0401, 64'd0, 32'd0));
        queue_item(make_item(OP_ADD, 64'd0, 64'd0, 32'h0000_0007));
        wait_idle();

        // Smallest capacity with one entry present: an add must be refused.
        write_capacity(4'd0);
        queue_item(make_item(OP_ADD, 64'd0, '1, '1));
        queue_item(make_item(OP_LOOKUP, 64'd0, 64'd0, 32'd0));
        wait_idle();

        // A capacity above the table size behaves like the table size.
        write_capacity(4'd15);
        queue_item(make_item(OP_ADD, 64'd0, 64'd0, 32'h1234_5678));
        queue_item(make_item(OP_ADD, 64'd0, '1, 32'h8765_4321));
        wait_idle();

        // Shrinking the capacity with entries in place hides the ones whose
        // index no longer fits the mask.
        write_capacity(4'd0);
        queue_item(make_item(OP_LOOKUP, 64'd1, 64'd0, 32'd0));
        queue_item(make_item(OP_DELETE, 64'd0, 64'd0, 32'd0));
        wait_idle();

        // Random part over several small capacities, where the table fills,
        // refuses adds and drains back to empty often.
        write_capacity(4'd2);
        run_random(100, 50);
        wait_idle();

        write_capacity(4'd0);
        run_random(60, 45);
        wait_idle();

        // Back pressure: the receiver holds off while requests keep coming,
        // so the block fills up and stops taking requests.
        write_capacity(4'd4);
        for (int k = 0; k < 30; k++)
            queue_item(random_item(50));
        hold_rsp = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp = 1'b0;
        run_random(100, 50);
        wait_idle();

        // A stretch at full speed on both sides.
        idle_on = 1'b0;
        write_capacity(4'd3);
        run_random(100, 50);
        wait_idle();
        idle_on = 1'b1;

        write_capacity(4'd1);
        run_random(50, 35);
        wait_idle();

        // Full table size with mostly adds, so the region doubles up to the
        // whole table.
        write_capacity(4'd10);
        run_random(620, 90);
        wait_idle();

        // Smaller capacity while hundreds of entries exist.
        write_capacity(4'd5);
        run_random(100, 50);
        wait_idle();

        // Delete every live entry, starting at a random slot, with a lookup
        // of a just-deleted id now and then.
        write_capacity(4'd10);
        start = $urandom_range(0, SLOTS - 1);
        for (int k = 0; k < SLOTS; k++) begin
            s = (start + k) % SLOTS;
            if (slot_used[s]) begin
                queue_item(make_item(OP_DELETE, slot_hid[s], {$urandom, $urandom}, $urandom));
                if ($urandom_range(0, 7) == 0)
                    queue_item(make_item(OP_LOOKUP, slot_hid[s], {$urandom, $urandom},
                                         $urandom));
            end
        end
        wait_idle();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
